// File: hw/rtl/mrrq_pkg.sv
// Shared types and constants of the round-robin multi-queue request FIFO.
package mrrq_pkg;

    localparam int PRODUCERS = 8;
    localparam int DEPTH     = 1024;

    localparam int PROD_W  = $clog2(PRODUCERS);
    localparam int PN_W    = $clog2(PRODUCERS + 1);
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = PROD_W + PTR_W;

    localparam int FIELD_PROD_W = 3;
    localparam int CTX_W        = 16;
    localparam int OFF_W        = 32;
    localparam int DEST_W       = 64;
    localparam int ENTRY_W      = CTX_W + OFF_W + DEST_W;
    localparam int S_TDATA_W    = 120;
    localparam int M_TDATA_W    = ENTRY_W;
    localparam int M_TUSER_W    = 2;

    localparam int CFG_W       = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(PRODUCERS);
    localparam logic REG_ACTIVE = 1'b0;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int RAM_DEPTH = PRODUCERS * DEPTH;

    typedef struct packed {
        logic               write;
        logic               read;
        logic               ok;
        logic               full;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } cmd_t;

endpackage

// File: hw/rtl/multi_producer_round_robin_queue_core.sv
// Top level of the round-robin multi-queue request FIFO.
//
// The block keeps one circular FIFO of read requests for each of 8 producers,
// each ring 1024 entries deep, in one shared single-port RAM of 8192 entries.
// An input item with s_tuser = 0 pushes its request onto the ring named by its
// producer field; a full ring refuses the push and the result item reports
// ring_full. An item with s_tuser = 1 pops: the search starts at a rotating
// pointer, covers the active rings (register active_producers; zero counts as
// one, above 8 as 8) and takes the oldest request of the first non-empty ring, and
// the pointer then rests just past the ring served. Every input item gives
// exactly one result item. The front end accepts one item per clock cycle while
// the command queue has room, and chooses the ring in that same cycle from the
// fill counts it keeps in flip-flops; a two-entry command queue then feeds the
// back end, which makes one RAM access per cycle. Sustained rate is one item per
// cycle while m_tready is high; a result passes through the command queue stage
// and then the registered RAM read before it appears. The ring storage needs no
// clearing pass after reset, since a pop reads only entries that a push wrote.
// Write active_producers only while the block is idle.
module multi_producer_round_robin_queue_core import mrrq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,   // op
    input  logic [S_TDATA_W-1:0]  s_tdata,   // producer, context_id, block_offset,
                                             // dest_address, zero pad
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TUSER_W-1:0]  m_tuser,   // done_ok, ring_full
    output logic [M_TDATA_W-1:0]  m_tdata    // context_out, offset_out, dest_out
);

    logic [CFG_W-1:0] active_reg;
    logic             cfg_write;
    logic             q_push_valid;
    cmd_t             q_push_cmd;
    logic             q_full;
    logic             q_pop_valid;
    cmd_t             q_pop_cmd;
    logic             q_pop_ready;

    // The single register occupies the first word; paddr[2] selects the word.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE);
    assign prdata    = (paddr[2] == REG_ACTIVE) ? APB_DATA_W'(active_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (cfg_write) begin
            active_reg <= pwdata[CFG_W-1:0];
        end
    end

    mrrq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .active_cfg (active_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .cmd_valid  (q_push_valid),
        .cmd        (q_push_cmd),
        .cmd_full   (q_full)
    );

    mrrq_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop_valid  (q_pop_valid),
        .pop_cmd    (q_pop_cmd),
        .pop_ready  (q_pop_ready)
    );

    mrrq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_pop_valid),
        .cmd       (q_pop_cmd),
        .cmd_ready (q_pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

// File: hw/rtl/mrrq_ram.sv
// Generic single-port RAM with registered read data.
module mrrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mrrq_front.sv
// Front end: accepts items, keeps ring pointers and fill counts, picks the ring to serve.
module mrrq_front import mrrq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CFG_W-1:0]     active_cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_full
);

    logic [PTR_W-1:0]  read_ptr_reg   [PRODUCERS];
    logic [PTR_W-1:0]  write_ptr_reg  [PRODUCERS];
    logic [CNT_W-1:0]  fill_count_reg [PRODUCERS];
    logic [PROD_W-1:0] rr_next_reg;
    logic [PROD_W-1:0] rr_next_next;

    logic                    s_accept;
    logic                    is_pop;
    logic [PROD_W-1:0]       push_prod;
    logic                    push_in_range;
    logic                    push_full;
    logic                    push_ok;
    logic [PN_W-1:0]         active_n;
    logic [PROD_W-1:0]       probe_start;
    logic [PROD_W-1:0]       probe_idx [PRODUCERS];
    logic [PRODUCERS-1:0]    probe_hit;
    logic                    pop_found;
    logic [PROD_W-1:0]       pop_sel;

    assign s_tready  = !cmd_full;
    assign s_accept  = s_tvalid && s_tready;
    assign is_pop    = (s_tuser == OP_POP);
    assign push_prod = PROD_W'(s_tdata[FIELD_PROD_W-1:0]);
    assign push_in_range = (32'(s_tdata[FIELD_PROD_W-1:0]) < PRODUCERS);
    assign push_full = (fill_count_reg[push_prod] == CNT_W'(DEPTH));
    assign push_ok   = push_in_range && !push_full;

    // Clamp the active ring count to 1 .. PRODUCERS.
    always_comb begin
        if (active_cfg == '0) begin
            active_n = PN_W'(1);
        end else if (32'(active_cfg) > PRODUCERS) begin
            active_n = PN_W'(PRODUCERS);
        end else begin
            active_n = PN_W'(active_cfg);
        end
    end

    assign probe_start = (PN_W'(rr_next_reg) >= active_n) ? '0 : rr_next_reg;

    // Rotating priority: probe slot k looks at ring (start + k) mod n.
    always_comb begin
        logic [PN_W-1:0] sum;
        for (int k = 0; k < PRODUCERS; k++) begin
            sum = PN_W'(probe_start) + PN_W'(k);
            probe_idx[k] = (sum >= active_n) ? PROD_W'(sum - active_n) : PROD_W'(sum);
            probe_hit[k] = (PN_W'(k) < active_n) && (fill_count_reg[probe_idx[k]] != '0);
        end
    end

    always_comb begin
        pop_found = 1'b0;
        pop_sel   = '0;
        for (int k = 0; k < PRODUCERS; k++) begin
            if (!pop_found && probe_hit[k]) begin
                pop_found = 1'b1;
                pop_sel   = probe_idx[k];
            end
        end
    end

    always_comb begin
        logic [PN_W-1:0] after;
        after = PN_W'(pop_sel) + PN_W'(1);
        if (!pop_found) begin
            rr_next_next = probe_start;
        end else if (after >= active_n) begin
            rr_next_next = '0;
        end else begin
            rr_next_next = PROD_W'(after);
        end
    end

    always_comb begin
        cmd       = '0;
        cmd.data  = s_tdata[FIELD_PROD_W +: ENTRY_W];
        cmd_valid = s_accept;
        if (is_pop) begin
            cmd.read = pop_found;
            cmd.ok   = pop_found;
            cmd.addr = {pop_sel, read_ptr_reg[pop_sel]};
        end else begin
            cmd.write = push_ok;
            cmd.ok    = push_ok;
            cmd.full  = push_in_range && push_full;
            cmd.addr  = {push_prod, write_ptr_reg[push_prod]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rr_next_reg <= '0;
            for (int p = 0; p < PRODUCERS; p++) begin
                read_ptr_reg[p]   <= '0;
                write_ptr_reg[p]  <= '0;
                fill_count_reg[p] <= '0;
            end
        end else if (s_accept) begin
            if (is_pop) begin
                rr_next_reg <= rr_next_next;
                if (pop_found) begin
                    read_ptr_reg[pop_sel] <=
                        (read_ptr_reg[pop_sel] == PTR_W'(DEPTH - 1)) ? '0
                                                                    : read_ptr_reg[pop_sel] + 1'b1;
                    fill_count_reg[pop_sel] <= fill_count_reg[pop_sel] - 1'b1;
                end
            end else if (push_ok) begin
                write_ptr_reg[push_prod] <=
                    (write_ptr_reg[push_prod] == PTR_W'(DEPTH - 1)) ? '0
                                                                    : write_ptr_reg[push_prod] + 1'b1;
                fill_count_reg[push_prod] <= fill_count_reg[push_prod] + 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !is_pop && push_ok) |=>
            fill_count_reg[$past(push_prod)] ==
            CNT_W'($past(fill_count_reg[push_prod]) + 1'b1))
        else $error("push did not raise the ring fill count by one");
    a_pop_from_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_pop && pop_found) |-> (fill_count_reg[pop_sel] != '0))
        else $error("pop chose an empty ring");
`endif

endmodule

// File: hw/rtl/mrrq_cmd_queue.sv
// Short command queue between the front end and the storage back end.
module mrrq_cmd_queue import mrrq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic full,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("command queue count beyond its depth");
`endif

endmodule

// File: hw/rtl/mrrq_back.sv
// Back end: carries out ring storage writes and reads and holds the result item.
module mrrq_back import mrrq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic               res_valid_reg;
    logic               res_ok_reg;
    logic               res_full_reg;
    logic               res_from_ram_reg;
    logic               take;
    logic [ENTRY_W-1:0] ram_rdata;

    // A command is taken only when the result slot is free or being emptied,
    // so the RAM read register holds the shown entry while the sink stalls.
    assign cmd_ready = !res_valid_reg || m_tready;
    assign take      = cmd_valid && cmd_ready;

    mrrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (take && cmd.write),
        .re    (take && cmd.read),
        .addr  (cmd.addr),
        .wdata (cmd.data),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (take) begin
            res_ok_reg       <= cmd.ok;
            res_full_reg     <= cmd.full;
            res_from_ram_reg <= cmd.read;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (cmd_ready) begin
            res_valid_reg <= cmd_valid;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tuser  = {res_full_reg, res_ok_reg};
    assign m_tdata  = res_from_ram_reg ? ram_rdata : '0;

`ifndef ASSERT_OFF
    a_read_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && cmd.read) |=> (res_valid_reg && res_from_ram_reg))
        else $error("storage read did not produce a result item");
    a_stall_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !m_tready) |=> (res_valid_reg && $stable(ram_rdata)))
        else $error("stalled result item lost its data");
`endif

endmodule

// File: tb/tb_multi_producer_round_robin_queue_core.sv
// Self-checking testbench for the round-robin multi-queue request FIFO.
module tb_multi_producer_round_robin_queue_core import mrrq_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // A request as it travels in both tdata buses: context id in the lowest bits,
    // then the block offset, then the destination address.
    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [OFF_W-1:0]  offset;
        logic [CTX_W-1:0]  context_id;
    } request_t;

    // What the block should report for one input item.
    typedef struct packed {
        logic     ring_full;
        logic     done_ok;
        request_t req;
    } outcome_t;

    // One input item waiting to be sent.
    typedef struct packed {
        logic                    op;
        logic [FIELD_PROD_W-1:0] producer;
        request_t                req;
    } queue_op_t;

    typedef enum logic [1:0] {
        RECEIVER_BUSY,
        SENDER_BUSY,
        NO_IDLE
    } idle_plan_e;

    localparam int REQ_W          = $bits(request_t);
    localparam int REG_BEYOND     = 1;      // first register index past the list
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 20;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic                  s_tuser  = 1'b0;   // op
    logic [S_TDATA_W-1:0]  s_tdata  = '0;     // producer, context_id, block_offset,
                                              // dest_address, zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TUSER_W-1:0]  m_tuser;           // done_ok, ring_full
    logic [M_TDATA_W-1:0]  m_tdata;           // context_out, offset_out, dest_out

    multi_producer_round_robin_queue_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Our own picture of the block: one queue per producer ring, the rotating
    // search pointer and the active ring count as last written.
    request_t             ring_store [PRODUCERS][$];
    logic [PROD_W-1:0]    rr_pointer     = '0;
    logic [CFG_W-1:0]     active_setting = ACTIVE_RESET;

    queue_op_t requests_to_send [$];
    outcome_t  outcomes_due [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    // Applies one accepted item to the rings and returns the result it causes.
    function automatic outcome_t serve_request(logic op, logic [FIELD_PROD_W-1:0] prod,
                                               request_t req);
        outcome_t res;
        int       n;
        int       cur;
        int       t;
        bit       found;
        res = '0;
        if (op == OP_PUSH) begin
            // A full ring refuses the push; nothing else changes.
            if (ring_store[prod].size() >= DEPTH) begin
                res.ring_full = 1'b1;
            end else begin
                ring_store[prod].insert(ring_store[prod].size(), req);
                res.done_ok = 1'b1;
            end
        end else begin
            // Zero active rings counts as one, anything past the ring count
            // as all of them.
            n = (active_setting == 0) ? 1 :
                (int'(active_setting) > PRODUCERS) ? PRODUCERS : int'(active_setting);
            // A pointer left beyond the active rings restarts at ring zero.
            cur = (int'(rr_pointer) >= n) ? 0 : int'(rr_pointer);
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!found) begin
                    t = cur;
                    cur = (cur + 1 >= n) ? 0 : cur + 1;
                    if (ring_store[t].size() != 0) begin
                        res.req = ring_store[t].pop_front();
                        res.done_ok = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            // An empty search probes every active ring once and so leaves the
            // pointer where it started.
            rr_pointer = PROD_W'(cur);
        end
        return res;
    endfunction

    function automatic request_t random_request();
        request_t req;
        req.context_id = CTX_W'($urandom);
        req.offset     = $urandom;
        req.dest       = {$urandom, $urandom};
        // Now and then push a field to one of its extremes.
        case ($urandom_range(7))
            0: req.context_id = '1;
            1: req.offset     = '0;
            2: req.dest       = '1;
            3: req = '0;
            default: ;
        endcase
        return req;
    endfunction

    task automatic queue_push(int prod, request_t req);
        requests_to_send.insert(requests_to_send.size(),
                                '{op: OP_PUSH, producer: FIELD_PROD_W'(prod), req: req});
    endtask

    // A pop carries random content in the push-only fields, which the block
    // must ignore.
    task automatic queue_pop();
        requests_to_send.insert(requests_to_send.size(),
                                '{op: OP_POP, producer: FIELD_PROD_W'($urandom),
                                  req: random_request()});
    endtask

    task automatic set_idle_plan(idle_plan_e plan);
        case (plan)
            RECEIVER_BUSY: begin
                send_idle_pct = 10;
                recv_idle_pct = 60;
            end
            SENDER_BUSY: begin
                send_idle_pct = 60;
                recv_idle_pct = 10;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Waits until every queued item has gone in and every result has come
    // back, then lets the pipeline settle.
    task automatic wait_idle();
        while (requests_to_send.size() != 0 || s_tvalid || outcomes_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(int index, logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * index);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == int'(REG_ACTIVE))
            active_setting = value[CFG_W-1:0];
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Driver: the item on the bus is predicted at the edge that accepts it,
    // and the next one (or a gap) is put up at that same edge.
    always @(posedge aclk) begin
        queue_op_t next_op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                outcomes_due.insert(outcomes_due.size(),
                                    serve_request(s_tuser, s_tdata[FIELD_PROD_W-1:0],
                                    request_t'(s_tdata[FIELD_PROD_W +: REQ_W])));
            if (!s_tvalid || s_tready) begin
                if (requests_to_send.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    next_op = requests_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_op.op;
                    s_tdata  <= S_TDATA_W'({next_op.req, next_op.producer});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, and every accepted result is held up
    // against the oldest prediction.
    always @(posedge aclk) begin
        outcome_t due;
        request_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (outcomes_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: tuser %h, tdata %h",
                                 m_tuser, m_tdata);
                end else begin
                    due = outcomes_due.pop_front();
                    got = request_t'(m_tdata);
                    check_field("done_ok", 64'(due.done_ok), 64'(m_tuser[0]));
                    check_field("ring_full", 64'(due.ring_full), 64'(m_tuser[1]));
                    check_field("context_out", 64'(due.req.context_id), 64'(got.context_id));
                    check_field("offset_out", 64'(due.req.offset), 64'(got.offset));
                    check_field("dest_out", due.req.dest, got.dest);
                end
            end
        end
    end

    // Watchdog: ends the run when neither side has moved an item for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[multi_producer_round_robin_queue_core] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int       fill_ring;
        int       fill_pushes;
        int       push_pct;
        int       backlog;
        int       phase_setting [RANDOM_PHASES];
        request_t mixed;
        phase_setting = '{1, 15, 4, 0, 8, 0};
        phase_setting[RANDOM_PHASES-1] = $urandom_range(15);
        mixed = '{dest: 64'h8000_0000_0000_0001, offset: 32'h8000_0001,
                  context_id: 16'hA5A5};

        set_idle_plan(RECEIVER_BUSY);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, all rings active after reset: a pop with nothing
        // stored, pushes with the field extremes, pops until empty again.
        queue_pop();
        queue_push(0, '0);
        queue_push(7, '1);
        queue_push(3, mixed);
        repeat (4) queue_pop();
        wait_idle();

        // An active count above the ring count behaves as all rings. The last
        // pop leaves the pointer at ring six.
        write_register(int'(REG_ACTIVE), 15);
        queue_push(6, random_request());
        queue_push(1, random_request());
        queue_pop();
        queue_pop();
        queue_push(5, random_request());
        queue_pop();
        wait_idle();

        // Three active rings with the pointer beyond them: the search restarts
        // at ring zero, and a push to inactive ring five is kept but not served.
        write_register(int'(REG_ACTIVE), 3);
        queue_push(5, random_request());
        queue_push(1, random_request());
        queue_push(0, random_request());
        repeat (3) queue_pop();
        wait_idle();

        // Zero active rings counts as one.
        write_register(int'(REG_ACTIVE), 0);
        queue_push(0, random_request());
        queue_pop();
        queue_pop();
        wait_idle();

        // A write past the register list changes nothing; with all rings
        // active again the request parked on ring five comes out.
        write_register(int'(REG_ACTIVE), 8);
        write_register(REG_BEYOND, 2);
        queue_pop();
        wait_idle();

        // Fill the last ring to the brim, which wraps its write side, and push
        // twice more to see it refused.
        fill_ring = PRODUCERS - 1;
        fill_pushes = DEPTH - ring_store[fill_ring].size() + 2;
        repeat (fill_pushes) queue_push(fill_ring, random_request());
        wait_idle();

        // Random phases over several active counts and push/pop mixes; the
        // idle plan moves from a busy receiver to a busy sender to none.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES / 3)
                set_idle_plan(SENDER_BUSY);
            else if (ph == 2 * RANDOM_PHASES / 3)
                set_idle_plan(NO_IDLE);
            write_register(int'(REG_ACTIVE),
                           ($urandom & ~32'hF) | APB_DATA_W'(phase_setting[ph]));
            push_pct = $urandom_range(30, 70);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < push_pct)
                    queue_push($urandom_range(PRODUCERS - 1), random_request());
                else
                    queue_pop();
            end
            wait_idle();
        end

        // Drain every ring but the last one, which stays out of the search,
        // and finish with a few pops on empty rings.
        write_register(int'(REG_ACTIVE), PRODUCERS - 1);
        backlog = 0;
        for (int r = 0; r < PRODUCERS - 1; r++)
            backlog += ring_store[r].size();
        repeat (backlog + 3) queue_pop();
        wait_idle();

        if (mismatch_count == 0)
            $display("[multi_producer_round_robin_queue_core] OK");
        else
            $display("[multi_producer_round_robin_queue_core] ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mrrq_pkg.sv
hw/rtl/mrrq_ram.sv
hw/rtl/mrrq_front.sv
hw/rtl/mrrq_cmd_queue.sv
hw/rtl/mrrq_back.sv
hw/rtl/multi_producer_round_robin_queue_core.sv
tb/tb_multi_producer_round_robin_queue_core.sv
